// ----- sv/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants for the bounded deque with front eviction.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int HANDLE_WIDTH_DEF = 32;

  localparam int CAP_W     = 7;
  localparam int OCC_W     = 7;
  localparam int CAP_RESET = 64;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_EVICT = 2'd3
  } status_t;

endpackage

// ----- sv/bounded_deque_with_front_eviction.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_front_eviction
// Bounded double-ended queue of handles; push-front evicts the back when full.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one operation per transfer:
//   push front, push back, pop front or pop back, plus the handle to store.
//   The output channel (out_valid/out_ready) returns exactly one result per
//   operation: a status, the popped or evicted handle (zero when none), and
//   the occupancy after the operation. The cfg channel writes the capacity;
//   it is always ready and should only be written while the block is idle.
//   The result is registered at the input transfer. Unless the receiver
//   stalls, throughput is one operation per cycle: pointers and count are
//   updated at the input transfer, the entry memory is read and written at
//   that edge, and its registered read data is the output handle register.
//   When the receiver stalls, the result register holds and in_ready drops
//   until the result is taken; a new operation may enter in the same cycle
//   the old result leaves.
//   Reset empties the queue and sets the capacity to 64. Memory contents are
//   not cleared; only occupied entries are ever returned.
// ----------------------------------------------------------------------------
module bounded_deque_with_front_eviction #(
  parameter int DEPTH        = bdq_pkg::DEPTH_DEF,
  parameter int HANDLE_WIDTH = bdq_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bdq_pkg::opcode_t               in_opcode,
  input  logic [HANDLE_WIDTH-1:0]        in_task_handle,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bdq_pkg::status_t               out_status,
  output logic [HANDLE_WIDTH-1:0]        out_handle,
  output logic [bdq_pkg::OCC_W-1:0]      out_occupancy,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bdq_pkg::CAP_W-1:0]      cfg_data
);
  import bdq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = PTR_W + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [HANDLE_WIDTH-1:0] mem [DEPTH];

  logic [PTR_W-1:0]        front_r, front_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CAP_W-1:0]        capacity_r;
  logic                    out_valid_r;
  status_t                 status_r, status_nxt;
  logic [OCC_W-1:0]        occ_r;
  logic                    use_r, use_nxt;
  logic [HANDLE_WIDTH-1:0] rd_data_r;

  logic                    accept;
  logic                    rd_en, wr_en;
  logic [PTR_W-1:0]        rd_addr, wr_addr;
  logic [CAP_W-1:0]        cap_nz;
  logic [CMP_W-1:0]        cap_eff, count_cmp;
  logic                    full, empty;
  logic [SUM_W-1:0]        back_off, back_sum, tail_sum, next_sum;
  logic [PTR_W-1:0]        back_addr, tail_addr, front_prev, front_next;

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_handle = use_r ? rd_data_r : '0;
  assign out_occupancy = occ_r;

  // Effective capacity: zero acts as one, and anything above DEPTH saturates.
  always_comb begin
    cap_nz    = (capacity_r == '0) ? CAP_W'(1) : capacity_r;
    cap_eff   = (CMP_W'(cap_nz) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_nz);
    count_cmp = CMP_W'(count_r);
    full      = count_cmp >= cap_eff;
    empty     = (count_r == '0);
  end

  // Slot arithmetic; sums stay below twice DEPTH, so one compare-subtract wraps.
  always_comb begin
    back_off  = empty ? '0 : SUM_W'(count_r) - SUM_W'(1);
    back_sum  = SUM_W'(front_r) + back_off;
    tail_sum  = SUM_W'(front_r) + SUM_W'(count_r);
    next_sum  = SUM_W'(front_r) + SUM_W'(1);
    back_addr = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
                                            : PTR_W'(back_sum);
    tail_addr = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                            : PTR_W'(tail_sum);
    front_next = (next_sum >= SUM_W'(DEPTH)) ? '0 : PTR_W'(next_sum);
    front_prev = (front_r == '0) ? PTR_W'(DEPTH - 1) : front_r - PTR_W'(1);
  end

  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    use_nxt    = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    rd_addr    = back_addr;
    wr_addr    = front_prev;
    case (in_opcode)
      OP_PUSH_FRONT: begin
        wr_en     = accept;
        wr_addr   = front_prev;
        front_nxt = front_prev;
        if (full) begin
          // The back entry is read at the same edge the new front is written,
          // so a full ring returns the old value even when the slots coincide.
          rd_en      = accept;
          rd_addr    = back_addr;
          use_nxt    = 1'b1;
          status_nxt = ST_EVICT;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = accept;
          wr_addr   = tail_addr;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en     = accept;
          rd_addr   = front_r;
          use_nxt   = 1'b1;
          front_nxt = front_next;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_en     = accept;
          rd_addr   = back_addr;
          use_nxt   = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        status_nxt = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_task_handle;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      capacity_r  <= CAP_W'(CAP_RESET);
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
      occ_r       <= '0;
      use_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
      if (accept) begin
        front_r     <= front_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
        status_r    <= status_nxt;
        occ_r       <= OCC_W'(count_nxt);
        use_r       <= use_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
